/* rtl/core/assert_macros.svh */
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PPA_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
		else $error("ppa check failed");

`define PPA_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons) \
	`PPA_ASSERT(lbl, clk_i, rst_ni, (ante) |-> (cons))

`endif

/* rtl/core/ppa_pkg.sv */
// Types, codes and constants of the per-CPU page allocator.
`timescale 1ns / 1ps

package ppa_pkg;

	localparam int NUM_CPUS_DEF  = 8;
	localparam int NUM_PAGES_DEF = 32768;

	localparam int FUNC_W     = 2;
	localparam int CPU_ID_W   = 3;
	localparam int ADDR_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int PAGE_OFS_W = 12;
	localparam int PAGE_W     = 20;
	localparam int LIMIT_W    = 21;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int PAGE_SPACE = 1 << PAGE_W;

	localparam logic [PAGE_W-1:0]  BASE_RST  = 20'd524288;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 21'd557056;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_LIMIT = 1'b1;

	typedef struct packed {
		logic accept_alloc;
		logic accept_free;
		logic accept_init;
		logic accept_nop;
		logic fill;
		logic alloc_wb;
	} ppa_cmd_t;

	typedef struct packed {
		logic alloc_found;
		logic init_empty;
		logic fill_last;
	} ppa_sts_t;

endpackage

/* rtl/core/ppa_ctrl.sv */
// Controller state machine of the per-CPU page allocator.
`timescale 1ns / 1ps

module ppa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppa_pkg::FUNC_W-1:0]    func,
	input  ppa_pkg::ppa_sts_t             sts,
	output ppa_pkg::ppa_cmd_t             cmd,
	output logic                          busy
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ALLOC = 2'd1;
	localparam logic [1:0] S_FILL  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (func)
						ppa_pkg::FUNC_ALLOC: begin
							cmd.accept_alloc = 1'b1;
							if (sts.alloc_found) begin
								state_d = S_ALLOC;
							end
						end
						ppa_pkg::FUNC_FREE: begin
							cmd.accept_free = 1'b1;
						end
						ppa_pkg::FUNC_INIT: begin
							cmd.accept_init = 1'b1;
							if (!sts.init_empty) begin
								state_d = S_FILL;
							end
						end
						default: begin
							cmd.accept_nop = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				cmd.alloc_wb = 1'b1;
				state_d      = S_IDLE;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* rtl/core/ppa_dpath.sv */
// Datapath of the per-CPU page allocator: list heads, counts, link memory, result beat.
`timescale 1ns / 1ps

module ppa_dpath #(
	parameter int NUM_CPUS  = ppa_pkg::NUM_CPUS_DEF,
	parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ppa_pkg::ppa_cmd_t               cmd,
	output ppa_pkg::ppa_sts_t               sts,
	input  logic [ppa_pkg::CPU_ID_W-1:0]    cpu_id,
	input  logic [ppa_pkg::ADDR_W-1:0]      address,
	input  logic                            cfg_we,
	input  logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppa_pkg::LIMIT_W-1:0]     cfg_wdata,
	output logic                            done,
	output logic [ppa_pkg::STATUS_W-1:0]    status,
	output logic [ppa_pkg::ADDR_W-1:0]      page_address,
	output logic [ppa_pkg::CPU_ID_W-1:0]    source_cpu,
	output logic                            stolen
);

	localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int IDX_W = $clog2(NUM_PAGES);
	localparam int IW1   = IDX_W + 1;
	localparam int NW    = $clog2(NUM_PAGES + 1);
	localparam int PW    = ppa_pkg::PAGE_W;
	localparam int LW    = ppa_pkg::LIMIT_W;
	localparam int CW    = ppa_pkg::CNT_W;
	localparam int OW    = ppa_pkg::PAGE_OFS_W;
	localparam int AW    = ppa_pkg::ADDR_W;

	logic [PW-1:0]    base_q;
	logic [LW-1:0]    limit_q;
	logic [IDX_W-1:0] head_q [NUM_CPUS];
	logic [CW-1:0]    count_q [NUM_CPUS];
	logic [IDX_W-1:0] link_mem [NUM_PAGES];
	logic [IDX_W-1:0] link_rd_q;

	logic [NUM_CPUS-1:0] nonempty;
	logic [4:0]          cpu_v;
	logic [CPU_W-1:0]    cpu_idx;
	logic [CPU_W-1:0]    pick;
	logic [CPU_W-1:0]    sel;
	logic                found;
	logic [IDX_W-1:0]    head_sel;
	logic [CW-1:0]       count_sel;

	logic [PW-1:0] fr_page;
	logic [PW-1:0] fr_diff;
	logic          free_ok;

	logic [LW-1:0] lim_c;
	logic [LW-1:0] span;
	logic [NW-1:0] n_c;

	logic [IDX_W-1:0] fill_q;
	logic [NW-1:0]    n_q;
	logic [IW1-1:0]   fill_nx;
	logic             fill_last;

	logic [CPU_W-1:0] from_q;
	logic [IDX_W-1:0] idx_q;
	logic             alloc_stolen_q;
	logic [PW-1:0]    alloc_page;
	logic [4:0]       from_ext;

	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_wd;

	logic                         done_next;
	logic                         done_q;
	logic [ppa_pkg::STATUS_W-1:0] status_q;
	logic [AW-1:0]                page_address_q;
	logic [ppa_pkg::CPU_ID_W-1:0] source_cpu_q;
	logic                         stolen_q;

	for (genvar g = 0; g < NUM_CPUS; g++) begin : g_nonempty
		assign nonempty[g] = (count_q[g] != '0);
	end

	always_comb begin
		cpu_v = {2'b00, cpu_id};
		for (int k = 0; k < 8; k++) begin
			if (cpu_v >= 5'(NUM_CPUS)) begin
				cpu_v = cpu_v - 5'(NUM_CPUS);
			end
		end
		cpu_idx = cpu_v[CPU_W-1:0];
	end

	always_comb begin
		found = |nonempty;
		pick  = cpu_idx;
		if (!nonempty[cpu_idx]) begin
			for (int i = NUM_CPUS - 1; i >= 0; i--) begin
				if (nonempty[i]) begin
					pick = CPU_W'(i);
				end
			end
		end
	end

	assign sel       = cmd.accept_alloc ? pick : cpu_idx;
	assign head_sel  = head_q[sel];
	assign count_sel = count_q[sel];

	assign fr_page = address[AW-1:OW];
	assign fr_diff = fr_page - base_q;
	assign free_ok = (address[OW-1:0] == '0) && (fr_page >= base_q) &&
			({1'b0, fr_page} < limit_q) && ({1'b0, fr_diff} < LW'(NUM_PAGES));

	always_comb begin
		lim_c = (limit_q > LW'(ppa_pkg::PAGE_SPACE)) ? LW'(ppa_pkg::PAGE_SPACE) : limit_q;
		span  = (lim_c > {1'b0, base_q}) ? (lim_c - {1'b0, base_q}) : '0;
		n_c   = (span > LW'(NUM_PAGES)) ? NW'(NUM_PAGES) : NW'(span);
	end

	assign fill_nx   = {1'b0, fill_q} + IW1'(1);
	assign fill_last = (fill_nx == IW1'(n_q));

	assign sts.alloc_found = found;
	assign sts.init_empty  = (n_c == '0);
	assign sts.fill_last   = fill_last;

	always_comb begin
		mem_we = cmd.fill | (cmd.accept_free & free_ok);
		mem_wa = cmd.fill ? fill_q : fr_diff[IDX_W-1:0];
		if (cmd.fill) begin
			mem_wd = (fill_q == '0) ? '0 : (fill_q - IDX_W'(1));
		end else begin
			mem_wd = head_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		link_rd_q <= link_mem[head_sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= ppa_pkg::BASE_RST;
			limit_q <= ppa_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppa_pkg::REG_POOL_BASE:  base_q  <= cfg_wdata[PW-1:0];
				ppa_pkg::REG_POOL_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cmd.accept_init) begin
				for (int i = 0; i < NUM_CPUS; i++) begin
					head_q[i]  <= '0;
					count_q[i] <= '0;
				end
			end
			if (cmd.accept_free && free_ok) begin
				head_q[sel] <= fr_diff[IDX_W-1:0];
				if (count_sel != '1) begin
					count_q[sel] <= count_sel + CW'(1);
				end
			end
			if (cmd.accept_alloc && found) begin
				count_q[sel] <= count_sel - CW'(1);
			end
			if (cmd.alloc_wb) begin
				head_q[from_q] <= link_rd_q;
			end
			if (cmd.fill && fill_last) begin
				head_q[0]  <= fill_q;
				count_q[0] <= CW'(n_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_alloc) begin
			from_q         <= pick;
			idx_q          <= head_sel;
			alloc_stolen_q <= (pick != cpu_idx);
		end
		if (cmd.accept_init) begin
			n_q    <= n_c;
			fill_q <= '0;
		end else if (cmd.fill) begin
			fill_q <= fill_q + IDX_W'(1);
		end
	end

	assign alloc_page = base_q + PW'(idx_q);
	assign from_ext   = 5'(from_q);

	assign done_next = cmd.accept_free | cmd.accept_nop |
			(cmd.accept_init & sts.init_empty) | (cmd.accept_alloc & ~found) |
			cmd.alloc_wb | (cmd.fill & fill_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= done_next;
		end
	end

	always_ff @(posedge clk) begin
		if (done_next) begin
			status_q       <= ppa_pkg::ST_DONE;
			page_address_q <= '0;
			source_cpu_q   <= '0;
			stolen_q       <= 1'b0;
			if (cmd.accept_free && !free_ok) begin
				status_q <= ppa_pkg::ST_BAD_ADDR;
			end
			if (cmd.accept_alloc) begin
				status_q <= ppa_pkg::ST_OOM;
			end
			if (cmd.alloc_wb) begin
				page_address_q <= {alloc_page, {OW{1'b0}}};
				source_cpu_q   <= from_ext[ppa_pkg::CPU_ID_W-1:0];
				stolen_q       <= alloc_stolen_q;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign page_address = page_address_q;
	assign source_cpu   = source_cpu_q;
	assign stolen       = stolen_q;

endmodule

/* rtl/core/percpu_page_allocator_top.sv */
// Top level of the per-CPU page allocator.
`timescale 1ns / 1ps

// Page allocator with one LIFO free list per CPU over a pool of 4 KiB pages.
// An item is taken when start is high and busy is low; its one result beat
// appears on status, page_address, source_cpu and stolen while done is high,
// for exactly one cycle, and cannot be held off: capture it on done.
// Free, an unknown func, an alloc that finds every list empty and an init
// of an empty pool give done on the cycle after the item is taken.
// A successful alloc first reads the list head, then its next link comes
// through the registered read port of the link memory. Init of n pages fills
// the link memory, one write per cycle. Lists are empty after reset until
// the first init or valid free. Configuration writes are taken at any edge
// with cfg_we high; write only while idle: the block does not enforce it.
module percpu_page_allocator_top #(
	parameter int NUM_CPUS  = ppa_pkg::NUM_CPUS_DEF,
	parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ppa_pkg::FUNC_W-1:0]      func,
	input  logic [ppa_pkg::CPU_ID_W-1:0]    cpu_id,
	input  logic [ppa_pkg::ADDR_W-1:0]      address,
	output logic                            done,
	output logic [ppa_pkg::STATUS_W-1:0]    status,
	output logic [ppa_pkg::ADDR_W-1:0]      page_address,
	output logic [ppa_pkg::CPU_ID_W-1:0]    source_cpu,
	output logic                            stolen,
	input  logic                            cfg_we,
	input  logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppa_pkg::LIMIT_W-1:0]     cfg_wdata
);

	ppa_pkg::ppa_cmd_t cmd;
	ppa_pkg::ppa_sts_t sts;

	ppa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ppa_dpath #(
		.NUM_CPUS  (NUM_CPUS),
		.NUM_PAGES (NUM_PAGES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cpu_id       (cpu_id),
		.address      (address),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.page_address (page_address),
		.source_cpu   (source_cpu),
		.stolen       (stolen)
	);

endmodule

/* rtl/core/ppa_checker.sv */
// Port checker of the per-CPU page allocator and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppa_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [ppa_pkg::FUNC_W-1:0]      func,
	input logic                            done,
	input logic [ppa_pkg::STATUS_W-1:0]    status,
	input logic [ppa_pkg::ADDR_W-1:0]      page_address,
	input logic [ppa_pkg::CPU_ID_W-1:0]    source_cpu,
	input logic                            stolen
);

	`PPA_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`PPA_ASSERT(a_free_one_cycle, clk, arst_n, start && !busy && func == ppa_pkg::FUNC_FREE |=> done)
	`PPA_ASSERT_IMPL(a_fail_zero, clk, arst_n, done && status != ppa_pkg::ST_DONE, page_address == '0 && source_cpu == '0 && !stolen)
	`PPA_ASSERT_IMPL(a_beat_legal, clk, arst_n, done, page_address[11:0] == 12'h000 && (status == ppa_pkg::ST_DONE || status == ppa_pkg::ST_OOM || status == ppa_pkg::ST_BAD_ADDR))

endmodule

bind percpu_page_allocator_top ppa_port_checker u_ppa_port_checker (.*);

/* verif/ppa_checker.sv */
// Checker for the page allocator: watches requests, predicts each result beat and compares.
`timescale 1ns / 1ps

module ppa_checker
	import ppa_pkg::*;
#(
	parameter int NUM_CPUS  = NUM_CPUS_DEF,
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [FUNC_W-1:0]     func,
	input  logic [CPU_ID_W-1:0]   cpu_id,
	input  logic [ADDR_W-1:0]     address,
	input  logic                  done,
	input  logic [STATUS_W-1:0]   status,
	input  logic [ADDR_W-1:0]     page_address,
	input  logic [CPU_ID_W-1:0]   source_cpu,
	input  logic                  stolen,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LIMIT_W-1:0]    cfg_wdata,
	output int                    fail_count,
	output int                    pending,
	output int                    beats_checked,
	output int                    steals_seen
);

	localparam int IDX_W = $clog2(NUM_PAGES);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   page_address;
		logic [CPU_ID_W-1:0] source_cpu;
		logic                stolen;
	} page_reply_t;

	logic [IDX_W-1:0]   link_mem [NUM_PAGES];
	logic [IDX_W-1:0]   head_idx [NUM_CPUS];
	logic [CNT_W-1:0]   page_cnt [NUM_CPUS];
	logic [PAGE_W-1:0]  base_pg;
	logic [LIMIT_W-1:0] limit_pg;

	page_reply_t replies_due[$];
	page_reply_t got_want;
	page_reply_t new_want;
	int          fails;
	int          checked;
	int          steals;

	task automatic push_page(input int unsigned c, input logic [IDX_W-1:0] idx);
		link_mem[idx] = head_idx[c];
		head_idx[c] = idx;
		if (page_cnt[c] != '1)
			page_cnt[c]++;
	endtask

	task automatic predict_request(input logic [FUNC_W-1:0] f, input logic [CPU_ID_W-1:0] c_raw,
			input logic [ADDR_W-1:0] a, output page_reply_t r);
		int unsigned      c;
		int unsigned      from;
		int unsigned      lim;
		int unsigned      n;
		int unsigned      pg;
		int               i;
		bit               found;
		logic [IDX_W-1:0] idx;
		r = '0;
		c = c_raw % NUM_CPUS;
		case (f)
			FUNC_ALLOC: begin
				from = c;
				found = page_cnt[c] != 0;
				for (i = 0; i < NUM_CPUS; i++)
					if (!found && i != c && page_cnt[i] != 0) begin
						from = i;
						found = 1'b1;
					end
				if (found) begin
					idx = head_idx[from];
					head_idx[from] = link_mem[idx];
					page_cnt[from]--;
					pg = base_pg + idx;
					r.page_address = pg << PAGE_OFS_W;
					r.source_cpu = CPU_ID_W'(from);
					r.stolen = from != c;
				end else begin
					r.status = ST_OOM;
				end
			end
			FUNC_FREE: begin
				pg = a >> PAGE_OFS_W;
				if (a[PAGE_OFS_W-1:0] != 0 || pg < base_pg || pg >= limit_pg ||
						pg - base_pg >= NUM_PAGES)
					r.status = ST_BAD_ADDR;
				else
					push_page(c, IDX_W'(pg - base_pg));
			end
			FUNC_INIT: begin
				lim = limit_pg;
				if (lim > PAGE_SPACE)
					lim = PAGE_SPACE;
				n = (lim > base_pg) ? lim - base_pg : 0;
				if (n > NUM_PAGES)
					n = NUM_PAGES;
				for (i = 0; i < NUM_CPUS; i++) begin
					head_idx[i] = '0;
					page_cnt[i] = '0;
				end
				for (i = 0; i < n; i++)
					push_page(0, IDX_W'(i));
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_idx[i] = '0;
				page_cnt[i] = '0;
			end
			base_pg = BASE_RST;
			limit_pg = LIMIT_RST;
			replies_due.delete();
			fails = 0;
			checked = 0;
			steals = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$display("%0t: result beat with none expected, status %0d page_address %h",
						$time, status, page_address);
					fails++;
				end else begin
					got_want = replies_due.pop_front();
					if (status !== got_want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, got_want.status, status);
						fails++;
					end
					if (page_address !== got_want.page_address) begin
						$display("%0t: page_address expected %h actual %h",
							$time, got_want.page_address, page_address);
						fails++;
					end
					if (source_cpu !== got_want.source_cpu) begin
						$display("%0t: source_cpu expected %0d actual %0d",
							$time, got_want.source_cpu, source_cpu);
						fails++;
					end
					if (stolen !== got_want.stolen) begin
						$display("%0t: stolen expected %0d actual %0d",
							$time, got_want.stolen, stolen);
						fails++;
					end
					checked++;
					if (got_want.stolen)
						steals++;
				end
			end
			if (start && !busy) begin
				predict_request(func, cpu_id, address, new_want);
				replies_due.push_back(new_want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_POOL_BASE:  base_pg = cfg_wdata[PAGE_W-1:0];
					REG_POOL_LIMIT: limit_pg = cfg_wdata;
					default: ;
				endcase
			end
		end
		fail_count <= fails;
		pending <= replies_due.size();
		beats_checked <= checked;
		steals_seen <= steals;
	end

endmodule

/* verif/tb.sv */
// Testbench top: drives requests and pool settings into the page allocator and gives the verdict.
`timescale 1ns / 1ps

module tb;
	import ppa_pkg::*;

	localparam int NUM_CPUS    = NUM_CPUS_DEF;
	localparam int NUM_PAGES   = NUM_PAGES_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 140;
	localparam int SMALL_POOL  = 64;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [FUNC_W-1:0]    func = FUNC_ALLOC;
	logic [CPU_ID_W-1:0]  cpu_id = '0;
	logic [ADDR_W-1:0]    address = '0;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [ADDR_W-1:0]    page_address;
	logic [CPU_ID_W-1:0]  source_cpu;
	logic                 stolen;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_POOL_BASE;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;

	int                   mismatches;
	int                   pending;
	int                   beats_checked;
	int                   steals_seen;
	int unsigned          cycles = 0;

	int unsigned          cur_base = BASE_RST;
	int unsigned          cur_limit = LIMIT_RST;
	int unsigned          b;
	int unsigned          l;
	int                   sent = 0;
	int                   settings = 1;
	int                   ph;
	int                   k;
	int                   gap;
	int                   idle_pct;
	int                   r;
	int                   pick;
	bit                   quiet;
	logic [FUNC_W-1:0]    f;
	logic [CPU_ID_W-1:0]  c;
	logic [ADDR_W-1:0]    a;

	percpu_page_allocator_top #(
		.NUM_CPUS(NUM_CPUS),
		.NUM_PAGES(NUM_PAGES)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .cpu_id(cpu_id), .address(address),
		.done(done), .status(status), .page_address(page_address),
		.source_cpu(source_cpu), .stolen(stolen),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	ppa_checker #(
		.NUM_CPUS(NUM_CPUS),
		.NUM_PAGES(NUM_PAGES)
	) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .cpu_id(cpu_id), .address(address),
		.done(done), .status(status), .page_address(page_address),
		.source_cpu(source_cpu), .stolen(stolen),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(mismatches), .pending(pending),
		.beats_checked(beats_checked), .steals_seen(steals_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int unsigned pool_span();
		int unsigned lim;
		int unsigned n;
		lim = (cur_limit > PAGE_SPACE) ? PAGE_SPACE : cur_limit;
		n = (lim > cur_base) ? lim - cur_base : 0;
		return (n > NUM_PAGES) ? NUM_PAGES : n;
	endfunction

	function automatic logic [ADDR_W-1:0] good_page_addr();
		int unsigned span;
		int unsigned pg;
		span = pool_span();
		pg = cur_base + $urandom_range(0, (span == 0) ? 0 : span - 1);
		return pg << PAGE_OFS_W;
	endfunction

	task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [CPU_ID_W-1:0] cpu,
			input logic [ADDR_W-1:0] addr, input int idle);
		if (idle > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		func = fn;
		cpu_id = cpu;
		address = addr;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_pool(input int unsigned base, input int unsigned limit);
		drain();
		write_reg(REG_POOL_BASE, LIMIT_W'(base));
		write_reg(REG_POOL_LIMIT, LIMIT_W'(limit));
		cur_base = base;
		cur_limit = limit;
		settings++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		issue_request(FUNC_ALLOC, 3'd0, '0, 0);
		issue_request(FUNC_UNUSED, 3'd7, '1, 0);
		issue_request(FUNC_INIT, 3'd0, '0, 0);
		issue_request(FUNC_ALLOC, 3'd0, '1, 0);
		issue_request(FUNC_ALLOC, 3'd7, '0, 1);
		issue_request(FUNC_FREE, 3'd3, {BASE_RST, 12'h000}, 0);
		issue_request(FUNC_ALLOC, 3'd3, '0, 0);
		issue_request(FUNC_FREE, 3'd1, {BASE_RST, 12'h001}, 0);
		issue_request(FUNC_FREE, 3'd1, {BASE_RST - 20'd1, 12'h000}, 0);
		issue_request(FUNC_FREE, 3'd2, {LIMIT_RST[PAGE_W-1:0], 12'h000}, 0);
		issue_request(FUNC_FREE, 3'd7, {LIMIT_RST[PAGE_W-1:0] - 20'd1, 12'h000}, 3);
		issue_request(FUNC_FREE, 3'd7, {LIMIT_RST[PAGE_W-1:0] - 20'd1, 12'h000}, 0);
		issue_request(FUNC_ALLOC, 3'd7, '0, 0);
		issue_request(FUNC_FREE, 3'd5, '1, 0);
		issue_request(FUNC_UNUSED, 3'd4, '0, 0);
		issue_request(FUNC_ALLOC, 3'd6, '0, 0);

		set_pool(0, 0);
		issue_request(FUNC_INIT, 3'd2, '1, 0);
		issue_request(FUNC_ALLOC, 3'd1, '0, 0);
		issue_request(FUNC_FREE, 3'd1, '0, 0);

		set_pool(PAGE_SPACE - 1, PAGE_SPACE);
		issue_request(FUNC_INIT, 3'd0, '0, 0);
		issue_request(FUNC_ALLOC, 3'd5, '0, 0);
		issue_request(FUNC_ALLOC, 3'd5, '0, 2);
		issue_request(FUNC_FREE, 3'd6, 32'hFFFF_F000, 0);
		issue_request(FUNC_ALLOC, 3'd6, '0, 0);
		issue_request(FUNC_FREE, 3'd4, 32'hFFFF_F000, 0);
		drain();
		write_reg(REG_POOL_BASE, LIMIT_W'(PAGE_SPACE - 2));
		cur_base = PAGE_SPACE - 2;
		settings++;
		issue_request(FUNC_ALLOC, 3'd4, '0, 0);
		sent = 26;

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				b = 0;
				l = PAGE_SPACE;
			end else if (ph == 7) begin
				b = PAGE_SPACE - $urandom_range(1, 40);
				l = PAGE_SPACE;
			end else if ($urandom_range(0, 9) == 0) begin
				b = $urandom_range(1, PAGE_SPACE - 1);
				l = $urandom_range(0, b);
			end else begin
				b = $urandom_range(0, PAGE_SPACE - 1 - SMALL_POOL);
				l = b + $urandom_range(1, SMALL_POOL);
			end
			set_pool(b, l);
			quiet = ph >= PHASES - 2;
			idle_pct = quiet ? 0 : $urandom_range(0, 40);
			issue_request(FUNC_INIT, CPU_ID_W'($urandom), $urandom, 0);
			sent++;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2 && ph % 3 == 1) begin
					// shift the base under live lists
					drain();
					cur_base = (cur_base >= 8) ? cur_base - $urandom_range(0, 8)
						: cur_base + $urandom_range(1, 8);
					write_reg(REG_POOL_BASE, LIMIT_W'(cur_base));
					settings++;
				end
				gap = (!quiet && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
				r = $urandom_range(0, 99);
				c = CPU_ID_W'($urandom);
				a = $urandom;
				if (r < 46) begin
					f = FUNC_ALLOC;
				end else if (r < 86) begin
					f = FUNC_FREE;
					pick = $urandom_range(0, 9);
					if (pick < 7)
						a = good_page_addr();
					else if (pick == 8)
						a = good_page_addr() | ADDR_W'($urandom_range(1, 4095));
					else if (pick == 9) begin
						case ($urandom_range(0, 2))
							0: a = cur_limit << PAGE_OFS_W;
							1: a = (cur_base - 1) << PAGE_OFS_W;
							default: a = (cur_base + NUM_PAGES) << PAGE_OFS_W;
						endcase
					end
				end else if (r < 89 && pool_span() <= SMALL_POOL) begin
					f = FUNC_INIT;
				end else if (r < 92) begin
					f = FUNC_UNUSED;
				end else begin
					f = FUNC_ALLOC;
				end
				issue_request(f, c, a, gap);
				sent++;
			end
		end

		drain();
		repeat (4) @(posedge clk);
		$display("Run covered %0d requests over %0d pool settings; %0d result beats checked.",
			sent, settings, beats_checked);
		$display("%0d allocations were served from another CPU's list.", steals_seen);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
